[src/pqme_pkg.sv]
// Shared types and constants for the peaceable queens move evaluator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pqme_pkg;

	localparam int CELL_W       = 5;   // bits of one board cell (0 empty, 1..31 colour)
	localparam int SCORE_W      = 34;  // signed width of the reported score
	localparam int WEIGHT_SHIFT = 16;  // score weight of the smallest army, 256*256

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_PLACE = 2'd1;
	localparam logic [1:0] CMD_TRY   = 2'd2;

	localparam logic [1:0] REG_COLOURS = 2'd0;
	localparam logic [1:0] REG_SIZE    = 2'd1;
	localparam logic [1:0] REG_MODE    = 2'd2;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_DECODE    = 13'b0000000000010,
		S_LOADROW   = 13'b0000000000100,
		S_CHECK     = 13'b0000000001000,
		S_ROWSCAN   = 13'b0000000010000,
		S_COLS      = 13'b0000000100000,
		S_COLDRAIN  = 13'b0000001000000,
		S_ARMY      = 13'b0000010000000,
		S_ARMYDRAIN = 13'b0000100000000,
		S_BAD       = 13'b0001000000000,
		S_DECIDE    = 13'b0010000000000,
		S_COMMITB   = 13'b0100000000000,
		S_FIN       = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic latch;
		logic rd_row;
		logic load_row;
		logic idx_clr;
		logic acc_clr;
		logic row_step;
		logic col_step;
		logic army_step;
		logic calc_bad;
		logic clear;
		logic commit_a;
		logic commit_b;
		logic flag_wr;
		logic flag_acc;
		logic flag_imp;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic cmd_clear;
		logic cmd_pt;
		logic cmd_place;
		logic op_err;
		logic same;
		logic idx_last_n;
		logic idx_last_c;
		logic any_army;
		logic clr_imp;
		logic new_ge;
		logic new_gt;
	} dp_status_t;

endpackage

[src/peaceable_queens_move_evaluator_core.sv]
// Top level of the peaceable queens move evaluator: sequencer plus datapath.
// Depends on pqme_pkg, pqme_ctrl, pqme_datapath and pqme_ram.
//
// A request is taken when start is high while busy is low; its one result
// appears on the result ports for exactly one cycle with done high, and the
// receiver cannot hold it off. A clear, an out-of-range operand or an unused
// command raises done without reading the board, and a cell that already
// holds the requested colour raises it after its row is read. A place or try
// that changes a cell walks the board before done (a refused try commits
// nothing), where N is the board size and C the number of colours in use:
// the board memory holds one row per word and is read one row per cycle, so
// the queens on the cell's row are counted from a held copy of that row, the
// column and both diagonals take N row reads, and the C army sizes are then
// walked one colour per cycle to find the smallest and largest army and the
// ties. Busy drops in the cycle in which done is high, so the next request
// can be taken at the edge that takes the result. Attack counts are not
// stored; they are gathered from the board on the row and column walks.
// Clearing is immediate through per-row and per-colour valid bits, so there is
// no clearing pass after reset. Configuration is to be written through cfg_we,
// cfg_index and cfg_data while idle, which the block itself does not enforce;
// changing the colour count or the board size clears the board.
module peaceable_queens_move_evaluator_core #(
	parameter int MAX_BOARD   = 32,
	parameter int MAX_COLOURS = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          command,
	input  logic [4:0]                          row,
	input  logic [4:0]                          column,
	input  logic [4:0]                          colour,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [5:0]                          cfg_data,
	output logic                                done,
	output logic                                accepted,
	output logic                                improved,
	output logic signed [pqme_pkg::SCORE_W-1:0] score,
	output logic [10:0]                         min_army,
	output logic [10:0]                         max_army,
	output logic [17:0]                         conflict_pairs,
	output logic                                operand_error
);

	pqme_pkg::dp_cmd_t    cmd;
	pqme_pkg::dp_status_t st;

	// The sequencer owns the order of the walk; the datapath owns all other state.
	pqme_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	pqme_datapath #(
		.MAX_BOARD   (MAX_BOARD),
		.MAX_COLOURS (MAX_COLOURS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.command        (command),
		.row            (row),
		.column         (column),
		.colour         (colour),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.accepted       (accepted),
		.improved       (improved),
		.score          (score),
		.min_army       (min_army),
		.max_army       (max_army),
		.conflict_pairs (conflict_pairs),
		.operand_error  (operand_error)
	);

endmodule

[src/pqme_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the board rows and the army sizes; depends on nothing.
module pqme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/pqme_ctrl.sv]
// Sequencer of the move evaluator: one-hot state machine issuing datapath commands.
// Depends on pqme_pkg for the state, command and status types.
module pqme_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pqme_pkg::dp_status_t  st,
	output pqme_pkg::dp_cmd_t     cmd
);

	pqme_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqme_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != pqme_pkg::S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			pqme_pkg::S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = pqme_pkg::S_DECODE;
				end
			end
			pqme_pkg::S_DECODE: begin
				if (st.cmd_clear) begin
					cmd.clear    = 1'b1;
					cmd.flag_wr  = 1'b1;
					cmd.flag_acc = st.any_army;
					cmd.flag_imp = st.clr_imp;
					state_d      = pqme_pkg::S_FIN;
				end else if (!st.cmd_pt || st.op_err) begin
					cmd.flag_wr = 1'b1;
					state_d     = pqme_pkg::S_FIN;
				end else begin
					cmd.rd_row = 1'b1;
					state_d    = pqme_pkg::S_LOADROW;
				end
			end
			pqme_pkg::S_LOADROW: begin
				cmd.load_row = 1'b1;
				state_d      = pqme_pkg::S_CHECK;
			end
			pqme_pkg::S_CHECK: begin
				if (st.same) begin
					cmd.flag_wr = 1'b1;
					state_d     = pqme_pkg::S_FIN;
				end else begin
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					state_d     = pqme_pkg::S_ROWSCAN;
				end
			end
			pqme_pkg::S_ROWSCAN: begin
				cmd.row_step = 1'b1;
				if (st.idx_last_n) begin
					cmd.idx_clr = 1'b1;
					state_d     = pqme_pkg::S_COLS;
				end
			end
			pqme_pkg::S_COLS: begin
				cmd.col_step = 1'b1;
				if (st.idx_last_n) begin
					state_d = pqme_pkg::S_COLDRAIN;
				end
			end
			pqme_pkg::S_COLDRAIN: begin
				cmd.idx_clr = 1'b1;
				state_d     = pqme_pkg::S_ARMY;
			end
			pqme_pkg::S_ARMY: begin
				cmd.army_step = 1'b1;
				if (st.idx_last_c) begin
					state_d = pqme_pkg::S_ARMYDRAIN;
				end
			end
			pqme_pkg::S_ARMYDRAIN: begin
				state_d = pqme_pkg::S_BAD;
			end
			pqme_pkg::S_BAD: begin
				cmd.calc_bad = 1'b1;
				state_d      = pqme_pkg::S_DECIDE;
			end
			pqme_pkg::S_DECIDE: begin
				cmd.flag_wr = 1'b1;
				if (st.cmd_place || st.new_ge) begin
					cmd.commit_a = 1'b1;
					cmd.flag_acc = 1'b1;
					cmd.flag_imp = st.new_gt;
					state_d      = pqme_pkg::S_COMMITB;
				end else begin
					state_d = pqme_pkg::S_FIN;
				end
			end
			pqme_pkg::S_COMMITB: begin
				cmd.commit_b = 1'b1;
				state_d      = pqme_pkg::S_FIN;
			end
			pqme_pkg::S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = pqme_pkg::S_IDLE;
			end
			default: begin
				state_d = pqme_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[src/pqme_datapath.sv]
// Datapath of the move evaluator: board and army memories, line-walk counters,
// army scan, score arithmetic, configuration registers and result registers.
// Depends on pqme_pkg and pqme_ram.
module pqme_datapath #(
	parameter int MAX_BOARD   = 32,
	parameter int MAX_COLOURS = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pqme_pkg::dp_cmd_t                   cmd,
	output pqme_pkg::dp_status_t                st,
	input  logic [1:0]                          command,
	input  logic [4:0]                          row,
	input  logic [4:0]                          column,
	input  logic [4:0]                          colour,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [5:0]                          cfg_data,
	output logic                                done,
	output logic                                accepted,
	output logic                                improved,
	output logic signed [pqme_pkg::SCORE_W-1:0] score,
	output logic [10:0]                         min_army,
	output logic [10:0]                         max_army,
	output logic [17:0]                         conflict_pairs,
	output logic                                operand_error
);

	localparam int CLW  = pqme_pkg::CELL_W;
	localparam int SCW  = pqme_pkg::SCORE_W;
	localparam int RA   = $clog2(MAX_BOARD);
	localparam int NW   = $clog2(MAX_BOARD + 1);
	localparam int IW   = (NW > 5) ? NW : 5;
	localparam int AD   = MAX_COLOURS + 1;
	localparam int AA   = $clog2(AD);
	localparam int AW   = $clog2(MAX_BOARD * MAX_BOARD + 1);
	localparam int TW   = $clog2(4 * MAX_BOARD + 1);
	localparam int PCW  = $clog2(4 * MAX_BOARD * MAX_BOARD * MAX_BOARD + 1);
	localparam int SW   = (PCW + 19 > 36) ? PCW + 19 : 36;
	localparam int PW   = ((RA > 5) ? RA : 5) + 2;
	localparam int BDW  = ((PCW > TW + 1) ? PCW : TW + 1) + 2;
	localparam int CMAX = (MAX_COLOURS < 31) ? MAX_COLOURS : 31;
	localparam int NRST = (MAX_BOARD < 32) ? MAX_BOARD : 32;

	typedef logic [MAX_BOARD-1:0][CLW-1:0] line_t;

	// Saturating score: (smallest army - conflicts) * 65536 + tail term.
	function automatic logic signed [SCW-1:0] score_f(input logic [AW-1:0] mn,
		input logic [PCW-1:0] bd, input logic [AW:0] tv);
		logic [SW-1:0] s;
		s = ((SW'(mn) - SW'(bd)) << pqme_pkg::WEIGHT_SHIFT) + SW'(tv);
		if (s[SW-1:SCW-1] == '0 || s[SW-1:SCW-1] == '1) begin
			score_f = s[SCW-1:0];
		end else if (s[SW-1]) begin
			score_f = {1'b1, {(SCW-1){1'b0}}};
		end else begin
			score_f = {1'b0, {(SCW-1){1'b1}}};
		end
	endfunction

	// Configuration and committed state.
	logic [4:0]     c_q;
	logic [NW-1:0]  n_q;
	logic           mode_q;
	logic [AW-1:0]  cur_min_q, cur_max_q;
	logic [4:0]     cur_extra_q;
	logic [PCW-1:0] conf_q;
	logic [MAX_BOARD-1:0] row_valid_q;
	logic [AD-1:0]        army_valid_q;

	// Latched request and working registers.
	logic [1:0]     op_q;
	logic [4:0]     row_q, col_q, val_q;
	line_t          line_q;
	logic [IW-1:0]  idx_q;
	logic [TW-1:0]  tot_q, nold_q, nval_q;
	logic [AW-1:0]  acc_min_q, acc_max_q, save_old_q, save_val_q;
	logic [4:0]     acc_ties_q;
	logic [PCW-1:0] bad_q;
	logic           flag_acc_q, flag_imp_q;

	// Pipeline registers behind the memory reads.
	logic           col_s1, army_s1, rvalid_s1, avalid_s1;
	logic [RA-1:0]  t_s1;
	logic [AA-1:0]  k_s1;

	// Memory ports.
	logic                 board_we, army_we;
	logic [RA-1:0]        board_raddr;
	logic [AA-1:0]        army_raddr, army_waddr;
	logic [MAX_BOARD*CLW-1:0] board_rdata;
	line_t                row_rd, rd_line, new_line;
	logic [AW-1:0]        army_rdata, army_wdata;

	// Combinational helpers.
	logic [4:0]     c_new, old;
	logic [5:0]     n_raw;
	logic [NW-1:0]  n_new;
	logic           cfg_clear, do_clear;
	logic [PW-1:0]  d1, d2;
	logic [2:0][CLW-1:0] sq;
	logic [2:0]     se;
	logic [1:0]     inc_tot, inc_old, inc_val;
	logic           nz;
	logic [AW-1:0]  a_cur, a_new;
	logic [BDW-1:0] bad_sum;
	logic [AW:0]    t_new, t_cur;
	logic signed [SCW-1:0] s_new, s_cur, s_empty;

	// Configuration values after clamping to the supported ranges.
	always_comb begin
		c_new = cfg_data[4:0];
		if (c_new < 5'd2) begin
			c_new = 5'd2;
		end else if (int'(c_new) > CMAX) begin
			c_new = 5'(CMAX);
		end
		n_raw = cfg_data;
		if (n_raw < 6'd4) begin
			n_raw = 6'd4;
		end else if (int'(n_raw) > MAX_BOARD) begin
			n_raw = 6'(MAX_BOARD);
		end
		n_new = NW'(n_raw);
	end

	assign cfg_clear = cfg_we && ((cfg_index == pqme_pkg::REG_COLOURS && c_new != c_q) ||
	                              (cfg_index == pqme_pkg::REG_SIZE && n_new != n_q));
	assign do_clear  = cmd.clear || cfg_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= 5'd2;
			n_q    <= NW'(NRST);
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pqme_pkg::REG_COLOURS: c_q    <= c_new;
				pqme_pkg::REG_SIZE:    n_q    <= n_new;
				pqme_pkg::REG_MODE:    mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Memories.
	assign board_raddr = cmd.rd_row ? RA'(row_q) : idx_q[RA-1:0];
	assign board_we    = cmd.commit_a;
	assign row_rd      = board_rdata;
	assign rd_line     = rvalid_s1 ? row_rd : '0;

	always_comb begin
		new_line = line_q;
		new_line[RA'(col_q)] = val_q;
	end

	pqme_ram #(.WIDTH(MAX_BOARD * CLW), .DEPTH(MAX_BOARD)) u_board_ram (
		.clk   (clk),
		.we    (board_we),
		.waddr (RA'(row_q)),
		.wdata (new_line),
		.raddr (board_raddr),
		.rdata (board_rdata)
	);

	assign old        = line_q[RA'(col_q)];
	assign army_raddr = AA'(idx_q + IW'(1));
	assign army_we    = (cmd.commit_a && old != 5'd0) || (cmd.commit_b && val_q != 5'd0);
	assign army_waddr = cmd.commit_b ? AA'(val_q) : AA'(old);
	assign army_wdata = cmd.commit_b ? save_val_q : save_old_q;

	pqme_ram #(.WIDTH(AW), .DEPTH(AD)) u_army_ram (
		.clk   (clk),
		.we    (army_we),
		.waddr (army_waddr),
		.wdata (army_wdata),
		.raddr (army_raddr),
		.rdata (army_rdata)
	);

	// Cells seen this cycle: one from the held row during the row walk, or up to
	// three (column, diagonal, anti-diagonal) from another row during the column walk.
	always_comb begin
		sq = '0;
		se = '0;
		d1 = PW'(col_q) + PW'(t_s1) - PW'(row_q);
		d2 = PW'(col_q) + PW'(row_q) - PW'(t_s1);
		if (cmd.row_step) begin
			sq[0] = line_q[idx_q[RA-1:0]];
			se[0] = 1'b1;
		end else if (col_s1 && PW'(t_s1) != PW'(row_q)) begin
			sq[0] = rd_line[RA'(col_q)];
			se[0] = 1'b1;
			sq[1] = rd_line[d1[RA-1:0]];
			se[1] = !d1[PW-1] && (d1 < PW'(n_q));
			sq[2] = rd_line[d2[RA-1:0]];
			se[2] = !d2[PW-1] && (d2 < PW'(n_q));
		end
	end

	always_comb begin
		inc_tot = '0;
		inc_old = '0;
		inc_val = '0;
		nz      = 1'b0;
		for (int i = 0; i < 3; i++) begin
			nz      = se[i] && sq[i] != '0;
			inc_tot = inc_tot + 2'(nz);
			inc_old = inc_old + 2'(nz && sq[i] == old);
			inc_val = inc_val + 2'(nz && sq[i] == val_q);
		end
	end

	// Army size of colour k_s1 after the proposed change.
	always_comb begin
		a_cur = avalid_s1 ? army_rdata : '0;
		a_new = a_cur;
		if (old != 5'd0 && k_s1 == AA'(old)) begin
			a_new = a_new - AW'(1);
		end
		if (val_q != 5'd0 && k_s1 == AA'(val_q)) begin
			a_new = a_new + AW'(1);
		end
	end

	// Conflict count after the change: each attacking pair counts twice, once per queen.
	always_comb begin
		bad_sum = BDW'(conf_q);
		if (val_q != 5'd0) begin
			bad_sum = bad_sum + (BDW'(tot_q - nval_q) << 1);
		end
		if (old != 5'd0) begin
			bad_sum = bad_sum - (BDW'(tot_q - nold_q) << 1);
		end
		if (old != 5'd0 && val_q != 5'd0) begin
			bad_sum = bad_sum - BDW'(2);
		end
	end

	assign t_new   = mode_q ? ((AW+1)'(c_q) + (AW+1)'(acc_max_q))
	                        : ((AW+1)'(c_q) - (AW+1)'(acc_ties_q));
	assign t_cur   = mode_q ? ((AW+1)'(c_q) + (AW+1)'(cur_max_q)) : (AW+1)'(cur_extra_q);
	assign s_new   = score_f(acc_min_q, bad_q, t_new);
	assign s_cur   = score_f(cur_min_q, conf_q, t_cur);
	assign s_empty = mode_q ? SCW'(c_q) : '0;

	// Working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_s1    <= 1'b0;
			army_s1   <= 1'b0;
			rvalid_s1 <= 1'b0;
			avalid_s1 <= 1'b0;
			idx_q     <= '0;
		end else begin
			col_s1    <= cmd.col_step;
			army_s1   <= cmd.army_step;
			rvalid_s1 <= row_valid_q[board_raddr];
			avalid_s1 <= army_valid_q[army_raddr];
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.row_step || cmd.col_step || cmd.army_step) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= idx_q[RA-1:0];
		k_s1 <= army_raddr;
		if (cmd.latch) begin
			op_q  <= command;
			row_q <= row;
			col_q <= column;
			val_q <= colour;
		end
		if (cmd.load_row) begin
			line_q <= rd_line;
		end
		if (cmd.acc_clr) begin
			tot_q  <= '0;
			nold_q <= '0;
			nval_q <= '0;
		end else begin
			tot_q  <= tot_q + TW'(inc_tot);
			nold_q <= nold_q + TW'(inc_old);
			nval_q <= nval_q + TW'(inc_val);
		end
		if (army_s1) begin
			if (k_s1 == AA'(1) || a_new < acc_min_q) begin
				acc_min_q  <= a_new;
				acc_ties_q <= 5'd1;
			end else if (a_new == acc_min_q) begin
				acc_ties_q <= acc_ties_q + 5'd1;
			end
			if (k_s1 == AA'(1) || a_new > acc_max_q) begin
				acc_max_q <= a_new;
			end
			if (old != 5'd0 && k_s1 == AA'(old)) begin
				save_old_q <= a_new;
			end
			if (val_q != 5'd0 && k_s1 == AA'(val_q)) begin
				save_val_q <= a_new;
			end
		end
		if (cmd.calc_bad) begin
			bad_q <= bad_sum[BDW-1] ? '0 : PCW'(bad_sum);
		end
	end

	// Committed board summary; cleared by the clear command or a write that changes the colour count or board size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			army_valid_q <= '0;
			cur_min_q    <= '0;
			cur_max_q    <= '0;
			cur_extra_q  <= '0;
			conf_q       <= '0;
		end else if (do_clear) begin
			row_valid_q  <= '0;
			army_valid_q <= '0;
			cur_min_q    <= '0;
			cur_max_q    <= '0;
			cur_extra_q  <= '0;
			conf_q       <= '0;
		end else begin
			if (cmd.commit_a) begin
				row_valid_q[RA'(row_q)] <= 1'b1;
				cur_min_q   <= acc_min_q;
				cur_max_q   <= acc_max_q;
				cur_extra_q <= c_q - acc_ties_q;
				conf_q      <= bad_q;
			end
			if (army_we) begin
				army_valid_q[army_waddr] <= 1'b1;
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done       <= 1'b0;
			flag_acc_q <= 1'b0;
			flag_imp_q <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.flag_wr) begin
				flag_acc_q <= cmd.flag_acc;
				flag_imp_q <= cmd.flag_imp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			accepted       <= flag_acc_q;
			improved       <= flag_imp_q;
			score          <= s_cur;
			min_army       <= 11'(cur_min_q);
			max_army       <= 11'(cur_max_q);
			conflict_pairs <= 18'(conf_q);
			operand_error  <= st.op_err;
		end
	end

	// Status to the sequencer.
	always_comb begin
		st.cmd_clear  = (op_q == pqme_pkg::CMD_CLEAR);
		st.cmd_place  = (op_q == pqme_pkg::CMD_PLACE);
		st.cmd_pt     = (op_q == pqme_pkg::CMD_PLACE) || (op_q == pqme_pkg::CMD_TRY);
		st.op_err     = st.cmd_pt && ((7'(row_q) >= 7'(n_q)) || (7'(col_q) >= 7'(n_q)) ||
		                              (val_q > c_q));
		st.same       = (old == val_q);
		st.idx_last_n = (idx_q == IW'(n_q - NW'(1)));
		st.idx_last_c = (idx_q == IW'(c_q - 5'd1));
		st.any_army   = (cur_max_q != '0);
		st.clr_imp    = (s_empty > s_cur);
		st.new_ge     = (s_new >= s_cur);
		st.new_gt     = (s_new > s_cur);
	end

endmodule

[test/testbench.sv]
// Self-checking testbench for peaceable_queens_move_evaluator_core.
// Depends on pqme_pkg and the core; a built-in predictor supplies results not fixed by hand.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// The fourth command code does nothing; the package gives it no name.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         STALL_LIMIT = 20000;
	localparam longint     SAT_LOW = -(64'sd1 <<< 33);
	localparam longint     SAT_HIGH = (64'sd1 <<< 33) - 1;

	typedef struct packed {
		logic        acc;
		logic        imp;
		logic [33:0] score;
		logic [10:0] mn;
		logic [10:0] mx;
		logic [17:0] conf;
		logic        err;
	} move_result_t;

	typedef struct {
		logic [1:0]   cmd;
		logic [4:0]   r;
		logic [4:0]   c;
		logic [4:0]   v;
		bit           typed;
		move_result_t res;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = '0;
	logic [4:0]  row = '0;
	logic [4:0]  column = '0;
	logic [4:0]  colour = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [5:0]  cfg_data = '0;
	logic        done;
	logic        accepted;
	logic        improved;
	logic signed [pqme_pkg::SCORE_W-1:0] score;
	logic [10:0] min_army;
	logic [10:0] max_army;
	logic [17:0] conflict_pairs;
	logic        operand_error;

	peaceable_queens_move_evaluator_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .row(row), .column(column), .colour(colour),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .accepted(accepted), .improved(improved), .score(score),
		.min_army(min_army), .max_army(max_army), .conflict_pairs(conflict_pairs),
		.operand_error(operand_error)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: the board, army sizes, conflict count, score and settings.
	// Attack counts are not kept; they are recounted from the board per move.
	int     model_colours;
	int     model_size;
	int     model_mode;
	int     board [32][32];
	int     army_size [32];
	longint conflicts;
	longint board_score;

	move_result_t pending_results [$];
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int stall_cycles = 0;
	int changes_kept = 0;
	bit gaps_enabled = 1'b1;

	function automatic int smallest_army(input int armies [32]);
		int k;
		int m;
		m = armies[1];
		for (k = 2; k <= model_colours; k++)
			if (armies[k] < m) m = armies[k];
		return m;
	endfunction

	function automatic int largest_army(input int armies [32]);
		int k;
		int m;
		m = armies[1];
		for (k = 2; k <= model_colours; k++)
			if (armies[k] > m) m = armies[k];
		return m;
	endfunction

	// Score: (smallest army - conflicts) * 2^16 plus the tie-break or largest-army term.
	function automatic longint score_for(input int armies [32], input longint bad);
		longint minq;
		longint s;
		int     k;
		int     ties;
		minq = smallest_army(armies);
		s = (minq - bad) * 65536;
		ties = 0;
		if (model_mode == 0) begin
			for (k = 1; k <= model_colours; k++)
				if (armies[k] == minq) ties++;
			s += model_colours - ties;
		end else begin
			s += model_colours + largest_army(armies);
		end
		if (s < SAT_LOW) s = SAT_LOW;
		if (s > SAT_HIGH) s = SAT_HIGH;
		return s;
	endfunction

	function automatic void clear_board();
		int r;
		int c;
		for (r = 0; r < 32; r++)
			for (c = 0; c < 32; c++)
				board[r][c] = 0;
		for (r = 0; r < 32; r++)
			army_size[r] = 0;
		conflicts = 0;
		board_score = score_for(army_size, 0);
	endfunction

	function automatic move_result_t evaluate_move(input logic [1:0] cmd, input int r,
			input int c, input int v);
		move_result_t res;
		int     k;
		int     r2;
		int     c2;
		int     dr;
		int     dc;
		int     old;
		int     armies [32];
		int     hits [32];
		longint bad;
		longint s;
		longint prev_score;
		prev_score = board_score;
		res = '0;
		if (cmd == pqme_pkg::CMD_CLEAR) begin
			for (k = 1; k < 32; k++)
				if (army_size[k] != 0) res.acc = 1'b1;
			clear_board();
		end else if (cmd == pqme_pkg::CMD_PLACE || cmd == pqme_pkg::CMD_TRY) begin
			if (r >= model_size || c >= model_size || v > model_colours) begin
				res.err = 1'b1;
			end else begin
				old = board[r][c];
				if (old != v) begin
					armies = army_size;
					if (old != 0) armies[old]--;
					if (v != 0) armies[v]++;
					// Queens of each colour that see the cell, the cell itself included.
					for (k = 0; k < 32; k++)
						hits[k] = 0;
					for (r2 = 0; r2 < model_size; r2++) begin
						for (c2 = 0; c2 < model_size; c2++) begin
							dr = r2 - r;
							dc = c2 - c;
							if (board[r2][c2] != 0 &&
									(dr == 0 || dc == 0 || dr == dc || dr == -dc))
								hits[board[r2][c2]]++;
						end
					end
					bad = conflicts;
					for (k = 1; k <= model_colours; k++) begin
						if (old != 0 && k != old) bad -= 2 * hits[k];
						if (v != 0 && k != v) bad += 2 * hits[k];
					end
					if (old != 0 && v != 0) bad -= 2;
					if (bad < 0) bad = 0;
					s = score_for(armies, bad);
					if (cmd == pqme_pkg::CMD_PLACE || s >= board_score) begin
						board[r][c] = v;
						army_size = armies;
						conflicts = bad;
						board_score = s;
						res.acc = 1'b1;
					end
				end
			end
		end
		res.imp = board_score > prev_score;
		res.score = board_score[33:0];
		res.mn = 11'(smallest_army(army_size));
		res.mx = 11'(largest_army(army_size));
		res.conf = conflicts[17:0];
		return res;
	endfunction

	// Results are checked against the oldest expectation; the watchdog counts
	// cycles in which neither a request nor a result moves.
	always @(posedge clk) begin
		move_result_t want;
		if (arst_n) begin
			if (done || (start && !busy)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (accepted !== want.acc) begin
					$error("accepted: expected %0d, got %0d", want.acc, accepted);
					errors++;
				end
				if (improved !== want.imp) begin
					$error("improved: expected %0d, got %0d", want.imp, improved);
					errors++;
				end
				if (score !== want.score) begin
					$error("score: expected %0d, got %0d", $signed(want.score), score);
					errors++;
				end
				if (min_army !== want.mn) begin
					$error("min_army: expected %0d, got %0d", want.mn, min_army);
					errors++;
				end
				if (max_army !== want.mx) begin
					$error("max_army: expected %0d, got %0d", want.mx, max_army);
					errors++;
				end
				if (conflict_pairs !== want.conf) begin
					$error("conflict_pairs: expected %0d, got %0d", want.conf,
						conflict_pairs);
					errors++;
				end
				if (operand_error !== want.err) begin
					$error("operand_error: expected %0d, got %0d", want.err, operand_error);
					errors++;
				end
			end
		end
	end

	// Called just after a rising edge. Holds the request until it is taken,
	// queues its expected result and sometimes leaves start low for a while.
	task automatic send_request(input logic [1:0] cmd, input logic [4:0] r,
			input logic [4:0] c, input logic [4:0] v, input bit typed,
			input move_result_t typed_res);
		move_result_t res;
		start <= 1'b1;
		command <= cmd;
		row <= r;
		column <= c;
		colour <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		res = evaluate_move(cmd, r, c, v);
		if (res.acc && cmd != pqme_pkg::CMD_CLEAR) changes_kept++;
		pending_results = {pending_results, (typed ? typed_res : res)};
		requests_sent++;
		if (gaps_enabled && $urandom_range(99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Waits until every result is in and the block is idle, plus some margin.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
		int v;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == pqme_pkg::REG_COLOURS) begin
			v = data & 31;
			if (v < 2) v = 2;
			if (v != model_colours) begin
				model_colours = v;
				clear_board();
			end
		end else if (idx == pqme_pkg::REG_SIZE) begin
			v = data;
			if (v < 4) v = 4;
			if (v > 32) v = 32;
			if (v != model_size) begin
				model_size = v;
				clear_board();
			end
		end else if (idx == pqme_pkg::REG_MODE) begin
			model_mode = data & 1;
			board_score = score_for(army_size, conflicts);
		end
	endtask

	task automatic configure(input logic [5:0] colours_raw, input logic [5:0] size_raw,
			input logic [5:0] mode_raw);
		write_reg(pqme_pkg::REG_COLOURS, colours_raw);
		write_reg(pqme_pkg::REG_SIZE, size_raw);
		write_reg(pqme_pkg::REG_MODE, mode_raw);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly in-range places and tries with random content; the rest is
	// clears, the unused command and places or tries with fully random operands.
	task automatic random_request();
		int pick;
		logic [1:0] cmd;
		logic [4:0] r;
		logic [4:0] c;
		logic [4:0] v;
		pick = $urandom_range(99);
		if (pick < 3) begin
			cmd = pqme_pkg::CMD_CLEAR;
			r = 5'($urandom);
			c = 5'($urandom);
			v = 5'($urandom);
		end else if (pick < 6) begin
			cmd = CMD_UNUSED;
			r = 5'($urandom);
			c = 5'($urandom);
			v = 5'($urandom);
		end else if (pick < 14) begin
			cmd = $urandom_range(1) ? pqme_pkg::CMD_PLACE : pqme_pkg::CMD_TRY;
			r = 5'($urandom);
			c = 5'($urandom);
			v = 5'($urandom);
		end else begin
			cmd = $urandom_range(99) < 40 ? pqme_pkg::CMD_PLACE : pqme_pkg::CMD_TRY;
			r = 5'($urandom_range(model_size - 1));
			c = 5'($urandom_range(model_size - 1));
			v = $urandom_range(99) < 15 ? 5'd0 : 5'($urandom_range(1, model_colours));
		end
		send_request(cmd, r, c, v, 1'b0, '0);
	endtask

	// Directed requests at the reset settings: two colours, a 32 by 32 board,
	// extra scoring. Only the first rows have results fixed by hand.
	directed_row_t directed [] = '{
		'{pqme_pkg::CMD_CLEAR, 5'd0,  5'd0,  5'd0,  1'b1, '0},
		'{pqme_pkg::CMD_PLACE, 5'd31, 5'd31, 5'd3,  1'b1, '{1'b0, 1'b0, 34'd0, 11'd0,
			11'd0, 18'd0, 1'b1}},
		'{CMD_UNUSED,          5'd4,  5'd4,  5'd1,  1'b1, '0},
		'{pqme_pkg::CMD_TRY,   5'd0,  5'd0,  5'd31, 1'b1, '{1'b0, 1'b0, 34'd0, 11'd0,
			11'd0, 18'd0, 1'b1}},
		'{pqme_pkg::CMD_PLACE, 5'd0,  5'd0,  5'd1,  1'b0, '0},
		'{pqme_pkg::CMD_PLACE, 5'd0,  5'd0,  5'd1,  1'b0, '0},
		'{pqme_pkg::CMD_PLACE, 5'd31, 5'd31, 5'd2,  1'b0, '0},
		'{pqme_pkg::CMD_PLACE, 5'd0,  5'd31, 5'd2,  1'b0, '0},
		'{pqme_pkg::CMD_TRY,   5'd5,  5'd7,  5'd1,  1'b0, '0},
		'{pqme_pkg::CMD_TRY,   5'd31, 5'd0,  5'd2,  1'b0, '0},
		'{pqme_pkg::CMD_TRY,   5'd0,  5'd31, 5'd1,  1'b0, '0},
		'{pqme_pkg::CMD_PLACE, 5'd0,  5'd31, 5'd0,  1'b0, '0},
		'{pqme_pkg::CMD_TRY,   5'd31, 5'd31, 5'd0,  1'b0, '0},
		'{pqme_pkg::CMD_PLACE, 5'd15, 5'd16, 5'd1,  1'b0, '0},
		'{pqme_pkg::CMD_PLACE, 5'd16, 5'd15, 5'd2,  1'b0, '0},
		'{pqme_pkg::CMD_TRY,   5'd16, 5'd15, 5'd1,  1'b0, '0},
		'{pqme_pkg::CMD_PLACE, 5'd10, 5'd21, 5'd2,  1'b0, '0},
		'{CMD_UNUSED,          5'd31, 5'd31, 5'd31, 1'b0, '0},
		'{pqme_pkg::CMD_CLEAR, 5'd31, 5'd31, 5'd31, 1'b0, '0},
		'{pqme_pkg::CMD_CLEAR, 5'd0,  5'd0,  5'd0,  1'b0, '0}
	};

	// Settings per random phase: raw colour count, raw board size, mode. Raw
	// values below or above the legal range exercise the clamping; the last
	// phase changes only the mode, so its board carries over.
	logic [5:0] phase_cfg [7][3] = '{
		'{6'd31, 6'd4,  6'd1},
		'{6'd5,  6'd63, 6'd0},
		'{6'd0,  6'd6,  6'd1},
		'{6'd37, 6'd0,  6'd0},
		'{6'd31, 6'd32, 6'd0},
		'{6'd3,  6'd8,  6'd1},
		'{6'd3,  6'd8,  6'd62}
	};

	initial begin
		int i;
		int p;
		model_colours = 2;
		model_size = 32;
		model_mode = 0;
		clear_board();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i].cmd, directed[i].r, directed[i].c, directed[i].v,
				directed[i].typed, directed[i].res);

		for (p = 0; p < 7; p++) begin
			drain();
			configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
			// One phase runs with start held high throughout.
			gaps_enabled = (p != 3);
			for (i = 0; i < 76; i++) begin
				random_request();
				// Let the pipeline empty once in mid-phase before going on.
				if (p == 1 && i == 38) drain();
			end
		end

		drain();
		repeat (150) @(posedge clk);
		$display("Sent %0d requests (%0d board changes kept), checked %0d results", requests_sent,
			changes_kept, results_checked);
		$display("over seven settings of colour count, board size and scoring mode.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
